// File: sv/glgcd_pkg.sv
// Shared constants, types and CORDIC angle table for the grid locator distance block.
package glgcd_pkg;

    localparam int STEPS       = 30;   // CORDIC iterations, also root bits
    localparam int ANG_W       = 14;   // folded half angle, 1/96 degree, 0..8640
    localparam int Q_W         = 30;   // unsigned Q29 value, 0..2^30-1
    localparam int CW          = 34;   // CORDIC x/y carrier
    localparam int ZW          = 33;   // CORDIC angle carrier
    localparam int RAD_W       = 60;   // square root radicand
    localparam int CHARS_W     = 48;
    localparam int LEN_W       = 3;
    localparam int RADIUS_W    = 13;
    localparam int DIST_W      = 15;
    localparam int QUEUE_DEPTH = 4;

    localparam int SINCOS_LAT  = 3 + STEPS;
    localparam int COMBINE_LAT = 3;
    localparam int BACK_LAT    = SINCOS_LAT + COMBINE_LAT + 2 * STEPS;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6367;
    localparam logic [Q_W-1:0]      ONE_Q29      = 30'd536870912;
    localparam logic [Q_W-1:0]      HALF_PI_Q29  = 30'd843314857;
    localparam logic signed [CW-1:0] GAIN_INV    = 34'sd326016437;

    // Classified locator pair: folded angles in 1/96 degree plus the validity flags
    typedef struct packed {
        logic [ANG_W-1:0] half_dlat;
        logic [ANG_W-1:0] half_dlon;
        logic [ANG_W-1:0] dbl_lat1;
        logic [ANG_W-1:0] dbl_lat2;
        logic             first_ok;
        logic             second_ok;
    } item_t;

    // atan(2^-i) in Q29, rounded
    function automatic logic [Q_W-1:0] atan_q29(input int unsigned i);
        logic [Q_W-1:0] r;
        case (i)
            0:       r = 30'd421657428;
            1:       r = 30'd248918915;
            2:       r = 30'd131521918;
            3:       r = 30'd66762579;
            4:       r = 30'd33510843;
            5:       r = 30'd16771758;
            6:       r = 30'd8387925;
            7:       r = 30'd4194219;
            8:       r = 30'd2097141;
            9:       r = 30'd1048575;
            default: r = (i <= 29) ? (30'd1 << (29 - i)) : 30'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/grid_locator_great_circle_distance.sv
// An accepted transaction passes the front register, the queue and the back end to its result.
// Throughput: one locator pair per cycle unless the output stalls; the four sine/cosine
// CORDICs, both square roots and the arctangent CORDIC are fully pipelined at one iteration
// per stage. A stalled output holds the whole back end; the queue absorbs the front meanwhile.
// Reset (aresetn low at a clock edge) empties the queue and pipeline, radius_km = 6367.
// Configuration is always ready; the radius is applied at the output stage, so write it idle.
module grid_locator_great_circle_distance #(
    parameter int QUEUE_DEPTH = glgcd_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [glgcd_pkg::CHARS_W-1:0]     s_first_square_chars,
    input  logic [glgcd_pkg::LEN_W-1:0]       s_first_square_length,
    input  logic [glgcd_pkg::CHARS_W-1:0]     s_second_square_chars,
    input  logic [glgcd_pkg::LEN_W-1:0]       s_second_square_length,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [glgcd_pkg::DIST_W-1:0]      m_distance_km,
    output logic                              m_first_valid,
    output logic                              m_second_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glgcd_pkg::RADIUS_W-1:0]    cfg_data
);

    logic             q_full, q_empty, q_push, q_pop;
    glgcd_pkg::item_t push_item, head_item;

    glgcd_front u_front (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_first_square_chars   (s_first_square_chars),
        .s_first_square_length  (s_first_square_length),
        .s_second_square_chars  (s_second_square_chars),
        .s_second_square_length (s_second_square_length),
        .q_full                 (q_full),
        .q_push                 (q_push),
        .q_item                 (push_item)
    );

    glgcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    glgcd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (!q_empty),
        .in_item        (head_item),
        .pop            (q_pop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance_km  (m_distance_km),
        .m_first_valid  (m_first_valid),
        .m_second_valid (m_second_valid)
    );

endmodule

// File: sv/glgcd_front.sv
// Input stage: takes a locator pair, checks both locators and folds the four angles.
module glgcd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [glgcd_pkg::CHARS_W-1:0]   s_first_square_chars,
    input  logic [glgcd_pkg::LEN_W-1:0]     s_first_square_length,
    input  logic [glgcd_pkg::CHARS_W-1:0]   s_second_square_chars,
    input  logic [glgcd_pkg::LEN_W-1:0]     s_second_square_length,
    input  logic                            q_full,
    output logic                            q_push,
    output glgcd_pkg::item_t                q_item
);

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] lat;   // 1/48 degree
        logic signed [15:0] lon;
    } loc_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= CH_LOW_A && c <= CH_LOW_Z) ? 8'(c - 8'd32) : c;
        return r;
    endfunction

    function automatic loc_t parse_loc(input logic [47:0] ch, input logic [2:0] len);
        logic [7:0]  b0, b1, b2, b3, b4, b5;
        logic        six;
        logic [15:0] f0, f1, d2, d3, s4, s5, off_lon, off_lat;
        loc_t        r;
        b0  = to_upper(ch[47:40]);
        b1  = to_upper(ch[39:32]);
        b2  = ch[31:24];
        b3  = ch[23:16];
        b4  = to_upper(ch[15:8]);
        b5  = to_upper(ch[7:0]);
        six = (len == 3'd6);
        r.ok = (len == 3'd4 || six)
            && b0 >= CH_A && b0 <= CH_R && b1 >= CH_A && b1 <= CH_R
            && b2 >= CH_0 && b2 <= CH_9 && b3 >= CH_0 && b3 <= CH_9
            && (!six || (b4 >= CH_A && b4 <= CH_X && b5 >= CH_A && b5 <= CH_X));
        f0 = {8'd0, 8'(b0 - CH_A)};
        f1 = {8'd0, 8'(b1 - CH_A)};
        d2 = {8'd0, 8'(b2 - CH_0)};
        d3 = {8'd0, 8'(b3 - CH_0)};
        s4 = {8'd0, 8'(b4 - CH_A)};
        s5 = {8'd0, 8'(b5 - CH_A)};
        off_lon = six ? 16'(s4 * 16'd4 + 16'd2) : 16'd48;
        off_lat = six ? 16'(s5 * 16'd2 + 16'd1) : 16'd24;
        // wraps in 16 bits, so the unsigned sum is the two's complement coordinate
        r.lon = $signed(16'(f0 * 16'd960 + d2 * 16'd96 + off_lon - 16'd8640));
        r.lat = $signed(16'(f1 * 16'd480 + d3 * 16'd48 + off_lat - 16'd4320));
        return r;
    endfunction

    // |v|, reflected about 90 degrees
    function automatic logic [glgcd_pkg::ANG_W-1:0] fold(input logic signed [15:0] v);
        logic [15:0] a;
        a = v[15] ? 16'(-v) : 16'(v);
        if (a > 16'd8640) begin
            a = 16'(16'd17280 - a);
        end
        return glgcd_pkg::ANG_W'(a);
    endfunction

    logic             vld_reg, vld_next;
    glgcd_pkg::item_t item_reg, item_next;
    loc_t             loc1, loc2;
    logic             take;

    assign s_ready = !vld_reg || !q_full;
    assign take    = s_valid && s_ready;
    assign q_push  = vld_reg && !q_full;
    assign q_item  = item_reg;

    always_comb begin
        loc1 = parse_loc(s_first_square_chars, s_first_square_length);
        loc2 = parse_loc(s_second_square_chars, s_second_square_length);
        item_next.half_dlat = fold(16'(loc2.lat - loc1.lat));
        item_next.half_dlon = fold(16'(loc2.lon - loc1.lon));
        item_next.dbl_lat1  = fold(16'(loc1.lat <<< 1));
        item_next.dbl_lat2  = fold(16'(loc2.lat <<< 1));
        item_next.first_ok  = loc1.ok;
        item_next.second_ok = loc2.ok;
    end

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (q_push) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: sv/glgcd_queue.sv
// Short FIFO between the classifying front stage and the arithmetic back end.
module glgcd_queue #(
    parameter int DEPTH = glgcd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  glgcd_pkg::item_t push_item,
    input  logic             pop,
    output glgcd_pkg::item_t head_item,
    output logic             empty,
    output logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    glgcd_pkg::item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == NW'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = NW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = NW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/glgcd_sincos.sv
// Pipelined angle-to-radian conversion and rotation CORDIC giving sine and cosine in Q29.
module glgcd_sincos (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [glgcd_pkg::ANG_W-1:0]   ang,
    output logic [glgcd_pkg::Q_W-1:0]     sin_q29,
    output logic [glgcd_pkg::Q_W-1:0]     cos_q29
);

    localparam int STEPS = glgcd_pkg::STEPS;
    localparam int CW    = glgcd_pkg::CW;
    localparam int ZW    = glgcd_pkg::ZW;

    // radians = (v*PI + 8640) / 17280 = v*97605 + (v*15313 + 8640) / 17280,
    // the last division done as (>>7) then a reciprocal multiply for /135
    logic [30:0] pa_reg, pb_reg;
    logic [27:0] ma_reg;
    logic [41:0] qb_reg;
    logic signed [ZW-1:0] z0_reg;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [ZW-1:0] z_reg [STEPS];
    logic signed [CW-1:0] x_next [STEPS];
    logic signed [CW-1:0] y_next [STEPS];
    logic signed [ZW-1:0] z_next [STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg <= {17'd0, ang} * 31'd97605;
            ma_reg <= {14'd0, ang} * 28'd15313 + 28'd8640;
            pb_reg <= pa_reg;
            qb_reg <= {21'd0, ma_reg[27:7]} * 42'd1988411;
            z0_reg <= $signed({2'b00, pb_reg} + {19'd0, qb_reg[41:28]});
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_iter
            logic signed [CW-1:0] xi, yi;
            logic signed [ZW-1:0] zi, at;
            always_comb begin
                if (i == 0) begin
                    xi = glgcd_pkg::GAIN_INV;
                    yi = '0;
                    zi = z0_reg;
                end else begin
                    xi = x_reg[i-1];
                    yi = y_reg[i-1];
                    zi = z_reg[i-1];
                end
                at = $signed({3'b000, glgcd_pkg::atan_q29(i)});
                if (!zi[ZW-1]) begin
                    x_next[i] = xi - (yi >>> i);
                    y_next[i] = yi + (xi >>> i);
                    z_next[i] = zi - at;
                end else begin
                    x_next[i] = xi + (yi >>> i);
                    y_next[i] = yi - (xi >>> i);
                    z_next[i] = zi + at;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_next[i];
                    y_reg[i] <= y_next[i];
                    z_reg[i] <= z_next[i];
                end
            end
        end
    endgenerate

    function automatic logic [glgcd_pkg::Q_W-1:0] clamp_q(input logic signed [CW-1:0] v);
        logic [glgcd_pkg::Q_W-1:0] r;
        if (v[CW-1]) begin
            r = '0;
        end else if (v > $signed({4'b0000, glgcd_pkg::ONE_Q29})) begin
            r = glgcd_pkg::ONE_Q29;
        end else begin
            r = v[glgcd_pkg::Q_W-1:0];
        end
        return r;
    endfunction

    assign sin_q29 = clamp_q(y_reg[STEPS-1]);
    assign cos_q29 = clamp_q(x_reg[STEPS-1]);

endmodule

// File: sv/glgcd_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module glgcd_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [glgcd_pkg::RAD_W-1:0]   radicand,
    output logic [glgcd_pkg::Q_W-1:0]     root
);

    localparam int STEPS = glgcd_pkg::STEPS;
    localparam int RAD_W = glgcd_pkg::RAD_W;
    localparam int Q_W   = glgcd_pkg::Q_W;

    logic [RAD_W-1:0] rem_reg  [STEPS];
    logic [Q_W-1:0]   root_reg [STEPS];
    logic [RAD_W-1:0] rem_next [STEPS];
    logic [Q_W-1:0]   root_next[STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_bit
            localparam int B = STEPS - 1 - k;
            logic [RAD_W-1:0] rem_in, trial;
            logic [Q_W-1:0]   root_in;
            always_comb begin
                if (k == 0) begin
                    rem_in  = radicand;
                    root_in = '0;
                end else begin
                    rem_in  = rem_reg[k-1];
                    root_in = root_reg[k-1];
                end
                // (r + 2^B)^2 - r^2
                trial = ({{(RAD_W-Q_W){1'b0}}, root_in} << (B + 1))
                      + (RAD_W'(1) << (2 * B));
                if (rem_in >= trial) begin
                    rem_next[k]  = rem_in - trial;
                    root_next[k] = root_in | (Q_W'(1) << B);
                end else begin
                    rem_next[k]  = rem_in;
                    root_next[k] = root_in;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                end
            end
        end
    endgenerate

    assign root = root_reg[STEPS-1];

endmodule

// File: sv/glgcd_vector.sv
// Pipelined vectoring CORDIC: arctangent of y/x in Q29 for nonnegative x and y.
module glgcd_vector (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [glgcd_pkg::Q_W-1:0]     x_in,
    input  logic [glgcd_pkg::Q_W-1:0]     y_in,
    output logic signed [glgcd_pkg::ZW-1:0] angle
);

    localparam int STEPS = glgcd_pkg::STEPS;
    localparam int CW    = glgcd_pkg::CW;
    localparam int ZW    = glgcd_pkg::ZW;
    localparam int Q_W   = glgcd_pkg::Q_W;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [ZW-1:0] z_reg [STEPS];
    logic signed [CW-1:0] x_next [STEPS];
    logic signed [CW-1:0] y_next [STEPS];
    logic signed [ZW-1:0] z_next [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_iter
            logic signed [CW-1:0] xi, yi;
            logic signed [ZW-1:0] zi, at;
            always_comb begin
                if (i == 0) begin
                    xi = $signed({{(CW-Q_W){1'b0}}, x_in});
                    yi = $signed({{(CW-Q_W){1'b0}}, y_in});
                    zi = '0;
                end else begin
                    xi = x_reg[i-1];
                    yi = y_reg[i-1];
                    zi = z_reg[i-1];
                end
                at = $signed({3'b000, glgcd_pkg::atan_q29(i)});
                if (!yi[CW-1] && yi != '0) begin
                    x_next[i] = xi + (yi >>> i);
                    y_next[i] = yi - (xi >>> i);
                    z_next[i] = zi + at;
                end else begin
                    x_next[i] = xi - (yi >>> i);
                    y_next[i] = yi + (xi >>> i);
                    z_next[i] = zi - at;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_next[i];
                    y_reg[i] <= y_next[i];
                    z_reg[i] <= z_next[i];
                end
            end
        end
    endgenerate

    assign angle = z_reg[STEPS-1];

endmodule

// File: sv/glgcd_back.sv
// Back end: haversine arithmetic pipeline, radius register and result output register.
module glgcd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  glgcd_pkg::item_t                  in_item,
    output logic                              pop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glgcd_pkg::RADIUS_W-1:0]    cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [glgcd_pkg::DIST_W-1:0]      m_distance_km,
    output logic                              m_first_valid,
    output logic                              m_second_valid
);

    localparam int Q_W      = glgcd_pkg::Q_W;
    localparam int ZW       = glgcd_pkg::ZW;
    localparam int RAD_W    = glgcd_pkg::RAD_W;
    localparam int LAT      = glgcd_pkg::BACK_LAT;
    localparam int RADIUS_W = glgcd_pkg::RADIUS_W;
    localparam int DIST_W   = glgcd_pkg::DIST_W;

    typedef struct packed {
        logic vld;
        logic first_ok;
        logic second_ok;
    } ctl_t;

    logic en;
    ctl_t ctl_reg [LAT];

    logic [RADIUS_W-1:0] radius_reg;

    logic [Q_W-1:0] s_dlat, s_dlon, c_lat1, c_lat2;
    logic [Q_W-1:0] sq1_reg, sq2_reg, pc_reg, sq1d_reg, t_reg;
    logic [2*Q_W-1:0] prod_sq1, prod_sq2, prod_pc, prod_t;
    logic [Q_W:0]   a_sum;
    logic [Q_W-1:0] a_cl;
    logic [RAD_W-1:0] rad_y_reg, rad_x_reg;
    logic [Q_W-1:0] root_y, root_x;
    logic signed [ZW-1:0] angle;
    logic [Q_W-1:0] angle_cl;
    logic [RADIUS_W+Q_W-1:0] scaled;

    logic              m_valid_reg, m_valid_next;
    logic [DIST_W-1:0] dist_reg;
    logic              v1_reg, v2_reg;

    // whole pipeline holds while a result waits at the output
    assign en        = !m_valid_reg || m_ready;
    assign pop       = en && in_valid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= glgcd_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                ctl_reg[k] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= '{vld: in_valid, first_ok: in_item.first_ok,
                            second_ok: in_item.second_ok};
            for (int k = 1; k < LAT; k++) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    glgcd_sincos u_sc_dlat (.aclk(aclk), .en(en), .ang(in_item.half_dlat),
                            .sin_q29(s_dlat), .cos_q29());
    glgcd_sincos u_sc_dlon (.aclk(aclk), .en(en), .ang(in_item.half_dlon),
                            .sin_q29(s_dlon), .cos_q29());
    glgcd_sincos u_sc_lat1 (.aclk(aclk), .en(en), .ang(in_item.dbl_lat1),
                            .sin_q29(), .cos_q29(c_lat1));
    glgcd_sincos u_sc_lat2 (.aclk(aclk), .en(en), .ang(in_item.dbl_lat2),
                            .sin_q29(), .cos_q29(c_lat2));

    // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
    always_comb begin
        prod_sq1 = {{Q_W{1'b0}}, s_dlat} * {{Q_W{1'b0}}, s_dlat};
        prod_sq2 = {{Q_W{1'b0}}, s_dlon} * {{Q_W{1'b0}}, s_dlon};
        prod_pc  = {{Q_W{1'b0}}, c_lat1} * {{Q_W{1'b0}}, c_lat2};
        prod_t   = {{Q_W{1'b0}}, pc_reg} * {{Q_W{1'b0}}, sq2_reg};
        a_sum    = {1'b0, sq1d_reg} + {1'b0, t_reg};
        a_cl     = (a_sum > {1'b0, glgcd_pkg::ONE_Q29}) ? glgcd_pkg::ONE_Q29
                                                        : a_sum[Q_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq1_reg   <= prod_sq1[58:29];
            sq2_reg   <= prod_sq2[58:29];
            pc_reg    <= prod_pc[58:29];
            sq1d_reg  <= sq1_reg;
            t_reg     <= prod_t[58:29];
            rad_y_reg <= {1'b0, a_cl, 29'd0};
            rad_x_reg <= {1'b0, Q_W'(glgcd_pkg::ONE_Q29 - a_cl), 29'd0};
        end
    end

    glgcd_isqrt u_sqrt_y (.aclk(aclk), .en(en), .radicand(rad_y_reg), .root(root_y));
    glgcd_isqrt u_sqrt_x (.aclk(aclk), .en(en), .radicand(rad_x_reg), .root(root_x));

    glgcd_vector u_atan (.aclk(aclk), .en(en), .x_in(root_x), .y_in(root_y), .angle(angle));

    always_comb begin
        if (angle[ZW-1]) begin
            angle_cl = '0;
        end else if (angle > $signed({3'b000, glgcd_pkg::HALF_PI_Q29})) begin
            angle_cl = glgcd_pkg::HALF_PI_Q29;
        end else begin
            angle_cl = angle[Q_W-1:0];
        end
        // (radius * 2 * angle) >> 29
        scaled = {{Q_W{1'b0}}, radius_reg} * {{RADIUS_W{1'b0}}, angle_cl};
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (en) begin
            m_valid_next = ctl_reg[LAT-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg   <= ctl_reg[LAT-1].first_ok;
            v2_reg   <= ctl_reg[LAT-1].second_ok;
            dist_reg <= (ctl_reg[LAT-1].first_ok && ctl_reg[LAT-1].second_ok)
                      ? scaled[RADIUS_W+Q_W-1:28] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_distance_km  = dist_reg;
    assign m_first_valid  = v1_reg;
    assign m_second_valid = v2_reg;

endmodule
